[rtl/core/srcl_pkg.sv]
// ----------------------------------------------------------------------------
// srcl_pkg
// Shared constants and types for the sparse row compress/lookup block.
// ----------------------------------------------------------------------------
package srcl_pkg;

  localparam int MAX_ROWS    = 32;
  localparam int MAX_COLS    = 32;
  localparam int MAX_ENTRIES = 1024;

  localparam int VAL_W  = 32;                      // element value
  localparam int IDX_W  = 5;                       // row / column fields
  localparam int DIM_W  = 6;                       // num_rows / num_cols
  localparam int CNT_W  = 11;                      // nonzero count
  localparam int ADDR_W = $clog2(MAX_ENTRIES);
  localparam int RS_DEPTH = MAX_ROWS + 1;
  localparam int RS_AW    = $clog2(RS_DEPTH);

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // input action codes
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // result status codes
  localparam logic STAT_OK    = 1'b0;
  localparam logic STAT_RANGE = 1'b1;

  // configuration register indexes
  localparam logic CFG_NUM_ROWS = 1'b0;
  localparam logic CFG_NUM_COLS = 1'b1;

  typedef enum logic [1:0] {
    REQ_LOAD,
    REQ_QUERY,
    REQ_QUERY_OOR
  } req_kind_t;

  typedef struct packed {
    req_kind_t          kind;
    logic               first;
    logic [VAL_W-1:0]   value;
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
  } req_t;

  // effective (clamped) matrix dimensions
  typedef struct packed {
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
  } dims_t;

endpackage

[rtl/core/srcl_front.sv]
// ----------------------------------------------------------------------------
// srcl_front
// Holds the dimension registers, accepts requests and tags each one as a
// load, an in-range query or an out-of-range query before queuing it.
// ----------------------------------------------------------------------------
module srcl_front import srcl_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_action,
  input  logic                    in_first,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic [IDX_W-1:0]        in_row,
  input  logic [IDX_W-1:0]        in_col,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [DIM_W-1:0]        cfg_data,
  input  logic                    q_full,
  output logic                    q_push,
  output req_t                    q_req,
  output dims_t                   dims
);

  logic [DIM_W-1:0] num_rows_r, num_rows_nxt;
  logic [DIM_W-1:0] num_cols_r, num_cols_nxt;
  logic             out_of_range;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > hi) r = hi;
    return r;
  endfunction

  always_comb begin
    num_rows_nxt = num_rows_r;
    num_cols_nxt = num_cols_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_ROWS: num_rows_nxt = cfg_data;
        CFG_NUM_COLS: num_cols_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r <= DIM_W'(MAX_ROWS);
      num_cols_r <= DIM_W'(MAX_COLS);
    end else begin
      num_rows_r <= num_rows_nxt;
      num_cols_r <= num_cols_nxt;
    end
  end

  assign dims.rows = clamp_dim(num_rows_r, DIM_W'(MAX_ROWS));
  assign dims.cols = clamp_dim(num_cols_r, DIM_W'(MAX_COLS));

  assign out_of_range = (DIM_W'(in_row) >= dims.rows) || (DIM_W'(in_col) >= dims.cols);

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    q_req.first = in_first;
    q_req.value = $unsigned(in_value);
    q_req.row   = in_row;
    q_req.col   = in_col;
    if (in_action == ACT_LOAD) q_req.kind = REQ_LOAD;
    else if (out_of_range)     q_req.kind = REQ_QUERY_OOR;
    else                       q_req.kind = REQ_QUERY;
  end

endmodule

[rtl/core/srcl_queue.sv]
// ----------------------------------------------------------------------------
// srcl_queue
// Small request FIFO between the front and the back end.
// ----------------------------------------------------------------------------
module srcl_queue import srcl_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  req_t push_req,
  input  logic pop,
  output req_t head,
  output logic empty,
  output logic full
);

  req_t            slot_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]   count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + Q_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + Q_AW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop)      count_nxt = count_r + (Q_AW+1)'(1);
    else if (pop && !push) count_nxt = count_r - (Q_AW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_req;
  end

endmodule

[rtl/core/srcl_back.sv]
// ----------------------------------------------------------------------------
// srcl_back
// Executes queued requests: compresses loads into the entry and row-start
// memories, scans one row per in-range query, and holds the result register.
// ----------------------------------------------------------------------------
module srcl_back import srcl_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dims_t                   dims,
  input  logic                    q_empty,
  input  req_t                    q_req,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] out_data,
  output logic                    out_status,
  output logic [CNT_W-1:0]        out_nonzero_count
);

  typedef enum logic [1:0] {ST_IDLE, ST_RS, ST_SCAN} state_t;

  localparam int ENT_W = IDX_W + VAL_W;

  state_t state_r, state_nxt;

  logic [IDX_W-1:0]    load_row_r, load_row_nxt;
  logic [IDX_W-1:0]    load_col_r, load_col_nxt;
  logic [CNT_W-1:0]    entry_count_r, entry_count_nxt;
  logic [RS_DEPTH-1:0] rs_valid_r, rs_valid_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    end_r, end_nxt;
  logic [IDX_W-1:0]    qcol_r, qcol_nxt;
  logic                pend_r, pend_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0] out_data_r, out_data_nxt;
  logic                    out_status_r, out_status_nxt;
  logic [CNT_W-1:0]        out_count_r, out_count_nxt;

  // memories
  logic [ENT_W-1:0] ent_mem [MAX_ENTRIES];
  logic [CNT_W-1:0] rs_mem  [RS_DEPTH];

  logic              ent_we, ent_re;
  logic [ADDR_W-1:0] ent_waddr, ent_raddr;
  logic [ENT_W-1:0]  ent_wdata, ent_rd_r;

  logic              rs_we, rs_re;
  logic [RS_AW-1:0]  rs_waddr, rs_lo_addr, rs_hi_addr;
  logic [CNT_W-1:0]  rs_wdata, rs_lo_r, rs_hi_r;
  logic              rs_lo_ok_r, rs_hi_ok_r;

  // load path
  logic             restart, store, row_end, mat_end, out_free, hit;
  logic [IDX_W-1:0] cur_row, cur_col;
  logic [CNT_W-1:0] base_cnt, new_cnt, start_q, hi_q;
  logic [RS_AW-1:0] next_row_addr;

  assign out_free = !out_valid_r || out_ready;

  assign restart  = q_req.first || (load_row_r == '0 && load_col_r == '0);
  assign cur_row  = restart ? '0 : load_row_r;
  assign cur_col  = restart ? '0 : load_col_r;
  assign base_cnt = restart ? '0 : entry_count_r;
  assign store    = (q_req.value != '0) && (base_cnt < CNT_W'(MAX_ENTRIES));
  assign new_cnt  = store ? base_cnt + CNT_W'(1) : base_cnt;
  assign row_end  = (DIM_W'(cur_col) + DIM_W'(1)) >= dims.cols;
  assign mat_end  = row_end && ((DIM_W'(cur_row) + DIM_W'(1)) >= dims.rows);
  assign next_row_addr = RS_AW'(cur_row) + RS_AW'(1);

  // a row start that was never written since the restart reads as zero
  assign start_q = rs_lo_ok_r ? rs_lo_r : '0;
  assign hi_q    = rs_hi_ok_r ? rs_hi_r : '0;

  assign hit = pend_r && (ent_rd_r[ENT_W-1 -: IDX_W] == qcol_r);

  always_comb begin
    state_nxt       = state_r;
    load_row_nxt    = load_row_r;
    load_col_nxt    = load_col_r;
    entry_count_nxt = entry_count_r;
    rs_valid_nxt    = rs_valid_r;
    idx_nxt         = idx_r;
    end_nxt         = end_r;
    qcol_nxt        = qcol_r;
    pend_nxt        = pend_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_data_nxt    = out_data_r;
    out_status_nxt  = out_status_r;
    out_count_nxt   = out_count_r;
    q_pop     = 1'b0;
    ent_we    = 1'b0;
    ent_waddr = base_cnt[ADDR_W-1:0];
    ent_wdata = {cur_col, q_req.value};
    ent_re    = 1'b0;
    ent_raddr = idx_r[ADDR_W-1:0];
    rs_we     = 1'b0;
    rs_waddr  = next_row_addr;
    rs_wdata  = new_cnt;
    rs_re     = 1'b0;
    rs_lo_addr = RS_AW'(q_req.row);
    rs_hi_addr = RS_AW'(q_req.row) + RS_AW'(1);

    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          case (q_req.kind)
            REQ_LOAD: begin
              if (!mat_end || out_free) begin
                q_pop           = 1'b1;
                ent_we          = store;
                entry_count_nxt = new_cnt;
                rs_valid_nxt    = restart ? '0 : rs_valid_r;
                if (row_end) begin
                  rs_we = 1'b1;
                  rs_valid_nxt[next_row_addr] = 1'b1;
                  load_col_nxt = '0;
                  load_row_nxt = mat_end ? '0 : cur_row + IDX_W'(1);
                end else begin
                  load_col_nxt = cur_col + IDX_W'(1);
                  load_row_nxt = cur_row;
                end
                if (mat_end) begin
                  out_valid_nxt  = 1'b1;
                  out_data_nxt   = '0;
                  out_status_nxt = STAT_OK;
                  out_count_nxt  = new_cnt;
                end
              end
            end
            REQ_QUERY_OOR: begin
              if (out_free) begin
                q_pop          = 1'b1;
                out_valid_nxt  = 1'b1;
                out_data_nxt   = '0;
                out_status_nxt = STAT_RANGE;
                out_count_nxt  = entry_count_r;
              end
            end
            REQ_QUERY: begin
              q_pop     = 1'b1;
              rs_re     = 1'b1;
              qcol_nxt  = q_req.col;
              state_nxt = ST_RS;
            end
            default: ;
          endcase
        end
      end
      ST_RS: begin
        idx_nxt   = start_q;
        end_nxt   = (hi_q > entry_count_r) ? entry_count_r : hi_q;
        pend_nxt  = 1'b0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (hit || idx_r >= end_r) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_data_nxt   = hit ? $signed(ent_rd_r[VAL_W-1:0]) : '0;
            out_status_nxt = STAT_OK;
            out_count_nxt  = entry_count_r;
            pend_nxt       = 1'b0;
            state_nxt      = ST_IDLE;
          end
        end else begin
          ent_re   = 1'b1;
          idx_nxt  = idx_r + CNT_W'(1);
          pend_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      load_row_r    <= '0;
      load_col_r    <= '0;
      entry_count_r <= '0;
      rs_valid_r    <= '0;
      pend_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      load_row_r    <= load_row_nxt;
      load_col_r    <= load_col_nxt;
      entry_count_r <= entry_count_nxt;
      rs_valid_r    <= rs_valid_nxt;
      pend_r        <= pend_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    end_r        <= end_nxt;
    qcol_r       <= qcol_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  // entry memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
    if (ent_re) ent_rd_r <= ent_mem[ent_raddr];
  end

  // row start memory: one write, two registered reads
  always_ff @(posedge clk) begin
    if (rs_we) rs_mem[rs_waddr] <= rs_wdata;
    if (rs_re) begin
      rs_lo_r    <= rs_mem[rs_lo_addr];
      rs_hi_r    <= rs_mem[rs_hi_addr];
      rs_lo_ok_r <= rs_valid_r[rs_lo_addr];
      rs_hi_ok_r <= rs_valid_r[rs_hi_addr];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_data          = out_data_r;
  assign out_status        = out_status_r;
  assign out_nonzero_count = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    entry_count_r <= CNT_W'(MAX_ENTRIES))
    else $error("entry count past store size");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (end_r <= entry_count_r))
    else $error("scan end past stored entries");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == ST_IDLE))
    else $error("request taken while busy");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_data_r)
                                     && $stable(out_count_r)))
    else $error("pending result overwritten");

endmodule

[rtl/core/sparse_row_compress_lookup.sv]
// ----------------------------------------------------------------------------
// sparse_row_compress_lookup
// Dense-to-CSR compressor with point lookup of stored elements.
// ----------------------------------------------------------------------------
// Input channel (in_*): valid/ready requests. A load (in_action = 0) carries
//   the next dense element in row-major order; in_first restarts the matrix.
//   A query (in_action = 1) asks for the element at in_row, in_col.
// Result channel (out_*): valid/ready. The last load of a matrix and every
//   query give one result; out_nonzero_count is the stored entry count.
// Config (cfg_*): write num_rows (index 0) / num_cols (index 1) while idle.
// Throughput: loads sustain one per cycle while no result is held back by
//   a stalled receiver at the last load of a matrix. A query holds the back
//   end through ST_RS and ST_SCAN, reading the stored entries of its row one
//   after another through the single read port of the entry memory, up to and
//   including the hit, and no new request is taken until its result is loaded;
//   an out-of-range query is answered from ST_IDLE with no scan.
// Reset: dimensions return to 32x32, the count and load position clear.
// A stalled receiver holds the result register; the back end waits when it
//   has a new result to give and the 4-deep queue keeps accepting until full.
// ----------------------------------------------------------------------------
module sparse_row_compress_lookup import srcl_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_action,
  input  logic                    in_first,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic [IDX_W-1:0]        in_row,
  input  logic [IDX_W-1:0]        in_col,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] out_data,
  output logic                    out_status,
  output logic [CNT_W-1:0]        out_nonzero_count,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [DIM_W-1:0]        cfg_data
);

  dims_t dims;
  req_t  push_req, head;
  logic  push, pop, q_empty, q_full;

  srcl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_action(in_action),
    .in_first (in_first),
    .in_value (in_value),
    .in_row   (in_row),
    .in_col   (in_col),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .q_full   (q_full),
    .q_push   (push),
    .q_req    (push_req),
    .dims     (dims)
  );

  srcl_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_req(push_req),
    .pop     (pop),
    .head    (head),
    .empty   (q_empty),
    .full    (q_full)
  );

  srcl_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .dims             (dims),
    .q_empty          (q_empty),
    .q_req            (head),
    .q_pop            (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data         (out_data),
    .out_status       (out_status),
    .out_nonzero_count(out_nonzero_count)
  );

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the CSR compressor with point lookup.
// Requests come from a queue filled per phase of matrix dimensions; each
// accepted request runs through a behavioral model of the compression and
// lookup, and every result is compared field by field with the oldest
// prediction. Phases vary the dimensions, including clamped values, and the
// source and sink gap patterns.
// ----------------------------------------------------------------------------
module tb;
  import srcl_pkg::*;

  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct {
    logic             action;
    logic             first;
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } matrix_req_t;

  typedef struct {
    logic signed [VAL_W-1:0] data;
    logic                    status;
    logic [CNT_W-1:0]        count;
  } lookup_result_t;

  typedef enum {GAP_NONE, GAP_SENDER, GAP_RECEIVER, GAP_BOTH} gap_mode_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    in_action = ACT_LOAD;
  logic                    in_first = 1'b0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic [IDX_W-1:0]        in_row = '0;
  logic [IDX_W-1:0]        in_col = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [VAL_W-1:0] out_data;
  logic                    out_status;
  logic [CNT_W-1:0]        out_nonzero_count;
  logic                    cfg_we = 1'b0;
  logic                    cfg_index = CFG_NUM_ROWS;
  logic [DIM_W-1:0]        cfg_data = '0;

  sparse_row_compress_lookup dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state: dimensions as written, CSR arrays, load position
  logic [DIM_W-1:0] dim_rows = DIM_W'(32);
  logic [DIM_W-1:0] dim_cols = DIM_W'(32);
  logic [VAL_W-1:0] csr_val [MAX_ENTRIES];
  logic [IDX_W-1:0] csr_col [MAX_ENTRIES];
  int               csr_row_start [RS_DEPTH] = '{default: 0};
  int               csr_count = 0;
  int               pos_row = 0;
  int               pos_col = 0;

  matrix_req_t      pending_reqs[$];
  lookup_result_t   expected_results[$];
  matrix_req_t      cur_req;
  lookup_result_t   want;
  gap_mode_t        gap_mode = GAP_NONE;

  int err_cnt = 0;
  int cycle_cnt = 0;
  int reqs_made = 0;
  int reqs_accepted = 0;
  int results_checked = 0;
  int matrices_closed = 0;
  int peak_count = 0;
  int phases_run = 0;

  function automatic int active_dim(logic [DIM_W-1:0] d, int hi);
    if (d < 1) return 1;
    if (d > hi) return hi;
    return d;
  endfunction

  function automatic void predict_result(matrix_req_t q);
    lookup_result_t res;
    int nr, nc, lo, hi;
    nr = active_dim(dim_rows, MAX_ROWS);
    nc = active_dim(dim_cols, MAX_COLS);
    res.data = '0;
    res.status = STAT_OK;
    if (q.action == ACT_LOAD) begin
      // explicit first flag, or position back at the origin, starts a new matrix
      if (q.first || (pos_row == 0 && pos_col == 0)) begin
        csr_row_start = '{default: 0};
        csr_count = 0;
        pos_row = 0;
        pos_col = 0;
      end
      if (pos_row >= MAX_ROWS) pos_row = MAX_ROWS - 1;
      if (pos_col == 0) csr_row_start[pos_row] = csr_count;
      if (q.value != '0 && csr_count < MAX_ENTRIES) begin
        csr_val[csr_count] = q.value;
        csr_col[csr_count] = IDX_W'(pos_col);
        csr_count++;
      end
      if (pos_col + 1 >= nc) begin
        csr_row_start[pos_row + 1] = csr_count;
        pos_col = 0;
        if (pos_row + 1 >= nr) begin
          pos_row = 0;
          res.count = CNT_W'(csr_count);
          expected_results.push_back(res);
          matrices_closed++;
        end else begin
          pos_row++;
        end
      end else begin
        pos_col++;
      end
    end else begin
      res.count = CNT_W'(csr_count);
      if (q.row >= nr || q.col >= nc) begin
        res.status = STAT_RANGE;
      end else begin
        lo = csr_row_start[q.row];
        hi = csr_row_start[int'(q.row) + 1];
        if (hi > csr_count) hi = csr_count;
        for (int i = lo; i < hi; i++) begin
          if (csr_col[i] == q.col) begin
            res.data = csr_val[i];
            break;
          end
        end
      end
      expected_results.push_back(res);
    end
  endfunction

  function automatic bit take_gap(bit rx_side);
    case (gap_mode)
      GAP_SENDER:   return !rx_side && ($urandom_range(0, 99) < 67);
      GAP_RECEIVER: return rx_side && ($urandom_range(0, 99) < 67);
      GAP_BOTH:     return $urandom_range(0, 99) < 15;
      default:      return 1'b0;
    endcase
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        predict_result(cur_req);
        reqs_accepted++;
      end
      if (pending_reqs.size() != 0 && !take_gap(1'b0)) begin
        cur_req = pending_reqs.pop_front();
        in_valid  <= 1'b1;
        in_action <= cur_req.action;
        in_first  <= cur_req.first;
        in_value  <= cur_req.value;
        in_row    <= cur_req.row;
        in_col    <= cur_req.col;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor and watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
        $error("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               expected_results.size());
        $display("FAIL sparse_row_compress_lookup");
        $finish;
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: data %0d status %0d count %0d",
                 out_data, out_status, out_nonzero_count);
          err_cnt++;
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (out_data !== want.data) begin
            $error("data mismatch: expected %0d, got %0d", want.data, out_data);
            err_cnt++;
          end
          if (out_status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, out_status);
            err_cnt++;
          end
          if (out_nonzero_count !== want.count) begin
            $error("nonzero_count mismatch: expected %0d, got %0d", want.count,
                   out_nonzero_count);
            err_cnt++;
          end
          if (want.count > peak_count) peak_count = want.count;
        end
      end
      out_ready <= !take_gap(1'b1);
    end
  end

  function automatic void push_req(logic act, logic fst, logic [VAL_W-1:0] v,
                                   logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
    matrix_req_t q;
    q.action = act;
    q.first  = fst;
    q.value  = v;
    q.row    = r;
    q.col    = c;
    pending_reqs.push_back(q);
    reqs_made++;
  endfunction

  function automatic logic [VAL_W-1:0] rand_elem(int dense_pct);
    logic [VAL_W-1:0] v;
    if ($urandom_range(0, 99) >= dense_pct) return '0;
    case ($urandom_range(0, 7))
      0:       v = 32'h7FFF_FFFF;
      1:       v = 32'h8000_0000;
      2:       v = 32'hFFFF_FFFF;
      3:       v = 32'h1;
      default: v = $urandom;
    endcase
    if (v == '0) v = 32'h1;
    return v;
  endfunction

  // mostly in range of the active dimensions, some anywhere in the field
  function automatic void gen_query();
    int nr, nc;
    logic [IDX_W-1:0] r, c;
    nr = active_dim(dim_rows, MAX_ROWS);
    nc = active_dim(dim_cols, MAX_COLS);
    if ($urandom_range(0, 4) != 0) begin
      r = IDX_W'($urandom_range(0, nr - 1));
      c = IDX_W'($urandom_range(0, nc - 1));
    end else begin
      r = IDX_W'($urandom);
      c = IDX_W'($urandom);
    end
    push_req(ACT_QUERY, 1'($urandom_range(0, 1)), $urandom, r, c);
  endfunction

  function automatic void gen_matrix(int dense_pct, int qpct, bit fresh);
    int n;
    n = active_dim(dim_rows, MAX_ROWS) * active_dim(dim_cols, MAX_COLS);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < qpct) gen_query();
      push_req(ACT_LOAD, (i == 0) && (fresh || $urandom_range(0, 9) != 0),
               rand_elem(dense_pct), IDX_W'($urandom), IDX_W'($urandom));
    end
    repeat ($urandom_range(1, 4)) gen_query();
  endfunction

  function automatic void gen_phase(int n_items, int dense_pct, int qpct);
    int start, pick;
    start = reqs_made;
    while (reqs_made - start < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        gen_matrix(dense_pct, qpct, 1'b0);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 6)) gen_query();
      end else begin
        // stray loads, sometimes restarting mid-matrix
        repeat ($urandom_range(1, 6))
          push_req(ACT_LOAD, $urandom_range(0, 3) == 0, rand_elem(dense_pct),
                   IDX_W'($urandom), IDX_W'($urandom));
      end
    end
    // leave a matrix half loaded across the next dimension change
    if ($urandom_range(0, 1))
      repeat ($urandom_range(1, 5))
        push_req(ACT_LOAD, 1'b0, rand_elem(dense_pct), IDX_W'($urandom),
                 IDX_W'($urandom));
  endfunction

  task automatic settle();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_dim(logic idx, logic [DIM_W-1:0] d);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    if (idx == CFG_NUM_ROWS) dim_rows = d;
    else dim_cols = d;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic reconfigure(logic [DIM_W-1:0] r, logic [DIM_W-1:0] c, gap_mode_t m);
    settle();
    write_dim(CFG_NUM_ROWS, r);
    write_dim(CFG_NUM_COLS, c);
    @(negedge clk);
    gap_mode = m;
    phases_run++;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset dimensions 32x32, nothing loaded yet
    @(negedge clk);
    push_req(ACT_QUERY, 1'b1, '0, 5'd0, 5'd0);
    push_req(ACT_QUERY, 1'b0, '0, 5'd31, 5'd31);

    // 2x3 matrix with value extremes, then lookups incl. out of range
    reconfigure(DIM_W'(2), DIM_W'(3), GAP_NONE);
    push_req(ACT_LOAD, 1'b1, 32'h7FFF_FFFF, '0, '0);
    push_req(ACT_LOAD, 1'b0, 32'h0, '0, '0);
    push_req(ACT_LOAD, 1'b0, 32'hFFFF_FFFF, '0, '0);
    push_req(ACT_LOAD, 1'b0, 32'h0, '0, '0);
    push_req(ACT_LOAD, 1'b0, 32'h8000_0000, '0, '0);
    push_req(ACT_LOAD, 1'b0, 32'h1, '0, '0);
    push_req(ACT_QUERY, 1'b0, '0, 5'd0, 5'd0);
    push_req(ACT_QUERY, 1'b0, '0, 5'd0, 5'd1);
    push_req(ACT_QUERY, 1'b0, '0, 5'd0, 5'd2);
    push_req(ACT_QUERY, 1'b0, '0, 5'd1, 5'd1);
    push_req(ACT_QUERY, 1'b0, '0, 5'd1, 5'd2);
    push_req(ACT_QUERY, 1'b0, '0, 5'd1, 5'd0);
    push_req(ACT_QUERY, 1'b0, '0, 5'd2, 5'd0);
    push_req(ACT_QUERY, 1'b0, '0, 5'd0, 5'd3);
    push_req(ACT_QUERY, 1'b1, '0, 5'd31, 5'd31);
    // implicit restart at the origin; unfinished rows look empty
    push_req(ACT_LOAD, 1'b0, 32'd5, '0, '0);
    push_req(ACT_QUERY, 1'b0, '0, 5'd0, 5'd0);
    push_req(ACT_LOAD, 1'b0, 32'd0, '0, '0);
    push_req(ACT_LOAD, 1'b0, 32'd9, '0, '0);
    push_req(ACT_QUERY, 1'b0, '0, 5'd0, 5'd2);
    push_req(ACT_QUERY, 1'b0, '0, 5'd1, 5'd0);
    // first flag mid-matrix throws the partial matrix away
    push_req(ACT_LOAD, 1'b1, 32'd7, '0, '0);
    push_req(ACT_QUERY, 1'b0, '0, 5'd0, 5'd0);

    // full 32x32 with every element nonzero: store fills completely
    reconfigure(DIM_W'(32), DIM_W'(32), GAP_NONE);
    gen_matrix(100, 3, 1'b1);
    repeat (30) gen_query();

    reconfigure(DIM_W'(1), DIM_W'(1), GAP_SENDER);
    gen_phase(30, 50, 30);
    reconfigure(DIM_W'(0), DIM_W'(0), GAP_RECEIVER);
    gen_phase(20, 50, 30);
    reconfigure(DIM_W'(1), DIM_W'(32), GAP_BOTH);
    gen_phase(40, 30, 20);
    reconfigure(DIM_W'(32), DIM_W'(1), GAP_NONE);
    gen_phase(40, 40, 20);
    reconfigure(DIM_W'(63), DIM_W'(2), GAP_SENDER);
    gen_phase(50, 30, 15);
    reconfigure(DIM_W'(0), DIM_W'(33), GAP_RECEIVER);
    gen_phase(30, 40, 20);
    reconfigure(DIM_W'($urandom_range(2, 8)), DIM_W'($urandom_range(2, 8)), GAP_BOTH);
    gen_phase(40, 35, 20);
    reconfigure(DIM_W'($urandom_range(2, 8)), DIM_W'($urandom_range(2, 8)), GAP_SENDER);
    gen_phase(40, 60, 25);
    reconfigure(DIM_W'(5), DIM_W'(7), GAP_RECEIVER);
    gen_phase(40, 25, 20);

    settle();
    $display("Checked %0d results from %0d requests over %0d dimension settings.",
             results_checked, reqs_accepted, phases_run + 1);
    $display("Closed %0d matrices; largest nonzero count seen %0d.",
             matrices_closed, peak_count);
    if (err_cnt == 0 && expected_results.size() == 0) begin
      $display("PASS sparse_row_compress_lookup");
    end else begin
      $display("FAIL sparse_row_compress_lookup");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/srcl_pkg.sv
rtl/core/srcl_front.sv
rtl/core/srcl_queue.sv
rtl/core/srcl_back.sv
rtl/core/sparse_row_compress_lookup.sv
test/tb.sv
